FILE: hw/rtl/sshlc_pkg.sv
// Package for the shutter switch hold/lock controller.
// Holds position, action and command codes, register indexes and the frame builder.
// No dependencies.
`timescale 1ns / 1ps

package sshlc_pkg;

   // configuration register file
   localparam int CFG_W            = 32;
   localparam logic [CFG_W-1:0] HOLD_DELAY_RST = 32'd2000;
   localparam logic [CFG_W-1:0] RUN_DELAY_RST  = 32'd60000;

   typedef enum logic [0:0] {
      REG_HOLD_DELAY = 1'b0,
      REG_RUN_DELAY  = 1'b1
   } reg_index_type;

   // request kinds
   typedef enum logic [0:0] {
      REQ_SAMPLE = 1'b0,
      REQ_CLEAR  = 1'b1
   } req_kind_type;

   // switch positions
   typedef enum logic [1:0] {
      POS_LOCKED  = 2'd0,
      POS_UP      = 2'd1,
      POS_DOWN    = 2'd2,
      POS_NEUTRAL = 2'd3
   } position_type;

   // result actions
   typedef enum logic [1:0] {
      ACT_BEEP = 2'd0,
      ACT_OFF  = 2'd1,
      ACT_UP   = 2'd2,
      ACT_DOWN = 2'd3
   } action_type;

   // bus target units
   localparam logic UNIT_SHUTTER = 1'b0;
   localparam logic UNIT_PANEL   = 1'b1;

   // bus commands
   localparam logic [2:0] CMD_BEEP = 3'h1;
   localparam logic [2:0] CMD_OFF  = 3'h1;
   localparam logic [2:0] CMD_UP   = 3'h2;
   localparam logic [2:0] CMD_DOWN = 3'h3;
   localparam logic [3:0] DATA_BEEP = 4'h1;

   // fixed field widths
   localparam int IDX_W = 3;
   localparam int POS_W = 2;
   localparam int NOW_W = 32;

   // bus byte: even-parity bit in bit 7, command in 6..4, data in 3..0
   function automatic logic [7:0] make_frame(input logic [2:0] cmd, input logic [3:0] data);
      logic [6:0] body;
      body = {cmd, data};
      return {^body, body};
   endfunction

endpackage

FILE: hw/rtl/sshlc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sshlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/shutter_switch_hold_lock_controller_unit.sv
// Top level of the shutter switch hold/lock controller.
// Depends on sshlc_pkg and sshlc_ram (per-switch position and change time).
`timescale 1ns / 1ps

// Usage
//   req_*  : one word per event. tuser 0 is a switch sample (index, position,
//            millisecond time), tuser 1 clears every switch to neutral at that time.
//   rsp_*  : at most one word per sample: action, target unit and the bus byte.
//   csr_*  : register writes, index 0 hold delay, index 1 run delay; always ready.
// Timing
//   One word accepted per cycle while the response channel is not stalled. A
//   word is accepted into stage 1 as its switch entry is read from the state
//   RAM, the decision is made and written back, and the result lands in the
//   output register, which drives rsp_tvalid. A write to a switch is
//   forwarded to a following word for the same switch, so consecutive
//   samples of one switch run at full rate.
//   The single RAM write port takes at most one update per cycle.
// Reset
//   All switches read as neutral with change time zero (per-entry valid bits;
//   an entry not yet written reads as neutral at the last clear time). Delays
//   return to 2000 ms and 60000 ms. No clearing pass is needed.
// Stall
//   While rsp_tready is low with a word held, the decision stage holds and
//   req_tready drops once that stage is occupied; nothing is lost.
module shutter_switch_hold_lock_controller_unit
   import sshlc_pkg::*;
#(
   parameter int NUM_SWITCHES = 4,
   parameter int TIME_BITS    = 32
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,   // switch_index[2:0], switch_position[4:3],
                                          // now_ms[36:5], zero pad [39:37]
   input  logic              req_tuser,   // req_type
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // action[1:0], target_unit[2],
                                          // frame_byte[10:3], zero pad [15:11]
   // register write channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_data
);

   localparam int ADDR_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
   localparam int ENT_W  = POS_W + TIME_BITS;
   localparam int CMP_W  = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

   // registers
   logic [CFG_W-1:0] hold_delay_ff;
   logic [CFG_W-1:0] run_delay_ff;

   // stage 1 (entry read, decision)
   logic                 s1_valid_ff;
   logic                 s1_clear_ff;
   logic                 s1_in_range_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic [IDX_W-1:0]     s1_idx_m1_ff;
   logic [POS_W-1:0]     s1_pos_ff;
   logic [TIME_BITS-1:0] s1_now_ff;
   logic                 s1_hit_ff;

   // switch state around the RAM
   logic [NUM_SWITCHES-1:0] entry_valid_ff;
   logic [TIME_BITS-1:0]    clear_time_ff;
   logic [ENT_W-1:0]        fwd_data_ff;

   // output register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_action_ff;
   logic        rsp_unit_ff;
   logic [7:0]  rsp_frame_ff;

   logic                 req_accept;
   logic                 advance;
   logic [IDX_W-1:0]     in_idx;
   logic [POS_W-1:0]     in_pos;
   logic [IDX_W-1:0]     in_idx_m1;
   logic [ADDR_W-1:0]    in_addr;
   logic                 in_range;

   logic                 wr_en;
   logic [ENT_W-1:0]     wr_data;
   logic [ENT_W-1:0]     rd_data;
   logic [ENT_W-1:0]     cur_entry;
   logic [POS_W-1:0]     old_pos;
   logic [TIME_BITS-1:0] old_time;
   logic [TIME_BITS-1:0] delta;
   logic                 held;
   logic                 in_run;
   logic                 do_write;
   logic [POS_W-1:0]     new_pos;
   logic                 has_result;
   logic [1:0]           res_action;
   logic                 res_unit;
   logic [7:0]           res_frame;

   // handshakes
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // input decode
   assign in_idx    = req_tdata[IDX_W-1:0];
   assign in_pos    = req_tdata[IDX_W+POS_W-1:IDX_W];
   assign in_idx_m1 = in_idx - IDX_W'(1);
   assign in_addr   = ADDR_W'(in_idx_m1);
   assign in_range  = (in_idx != '0) && ({29'd0, in_idx} <= NUM_SWITCHES);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_delay_ff <= HOLD_DELAY_RST;
         run_delay_ff  <= RUN_DELAY_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_HOLD_DELAY: hold_delay_ff <= csr_data;
            REG_RUN_DELAY:  run_delay_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // state RAM: {position, last change time} per switch
   sshlc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_SWITCHES)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (in_addr),
      .rd_data (rd_data)
   );

   // stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_clear_ff    <= (req_kind_type'(req_tuser) == REQ_CLEAR);
         s1_in_range_ff <= in_range;
         s1_addr_ff     <= in_addr;
         s1_idx_m1_ff   <= in_idx_m1;
         s1_pos_ff      <= in_pos;
         s1_now_ff      <= TIME_BITS'(req_tdata[IDX_W+POS_W+NOW_W-1:IDX_W+POS_W]);
         // the write landing at this edge is missed by the RAM read
         s1_hit_ff      <= wr_en && (s1_addr_ff == in_addr);
      end
   end

   // entry view: never written since clear reads neutral at clear time
   always_comb begin
      if (!entry_valid_ff[s1_addr_ff]) begin
         cur_entry = {POS_NEUTRAL, clear_time_ff};
      end else if (s1_hit_ff) begin
         cur_entry = fwd_data_ff;
      end else begin
         cur_entry = rd_data;
      end
   end

   assign old_pos  = cur_entry[ENT_W-1:TIME_BITS];
   assign old_time = cur_entry[TIME_BITS-1:0];
   assign delta    = s1_now_ff - old_time;
   assign held     = CMP_W'(delta) > CMP_W'(hold_delay_ff);
   assign in_run   = CMP_W'(delta) < CMP_W'(run_delay_ff);

   // decision
   always_comb begin
      do_write   = 1'b0;
      new_pos    = s1_pos_ff;
      has_result = 1'b0;
      res_action = ACT_OFF;
      res_unit   = UNIT_SHUTTER;
      res_frame  = make_frame(CMD_OFF, {1'b0, s1_idx_m1_ff});
      if (in_run && (s1_pos_ff == POS_NEUTRAL) && held) begin
         // neutral after hold inside run window: ignored
      end else if (in_run && (s1_pos_ff != POS_NEUTRAL) && (old_pos == s1_pos_ff) && held) begin
         has_result = 1'b1;
         res_action = ACT_BEEP;
         res_unit   = UNIT_PANEL;
         res_frame  = make_frame(CMD_BEEP, DATA_BEEP);
      end else if (old_pos != s1_pos_ff) begin
         do_write = 1'b1;
         if (old_pos != POS_LOCKED) begin
            if (held) begin
               new_pos    = POS_NEUTRAL;
               has_result = 1'b1;
            end else begin
               case (position_type'(s1_pos_ff))
                  POS_NEUTRAL: has_result = 1'b1;
                  POS_UP: begin
                     has_result = 1'b1;
                     res_action = ACT_UP;
                     res_frame  = make_frame(CMD_UP, {1'b0, s1_idx_m1_ff});
                  end
                  POS_DOWN: begin
                     has_result = 1'b1;
                     res_action = ACT_DOWN;
                     res_frame  = make_frame(CMD_DOWN, {1'b0, s1_idx_m1_ff});
                  end
                  default: has_result = 1'b0;
               endcase
            end
         end
      end
   end

   // write back only when the stage completes
   assign wr_en   = s1_valid_ff && advance && !s1_clear_ff && s1_in_range_ff && do_write;
   assign wr_data = {new_pos, s1_now_ff};

   // valid bits, clear time and forwarding copy
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         clear_time_ff  <= '0;
      end else if (s1_valid_ff && advance && s1_clear_ff) begin
         entry_valid_ff <= '0;
         clear_time_ff  <= s1_now_ff;
      end else if (wr_en) begin
         entry_valid_ff[s1_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff && !s1_clear_ff && s1_in_range_ff && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_action_ff <= res_action;
         rsp_unit_ff   <= res_unit;
         rsp_frame_ff  <= res_frame;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_frame_ff, rsp_unit_ff, rsp_action_ff};

   // checks
   a_wr_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (s1_valid_ff && advance))
      else $error("state write while decision stage stalled");

   a_clear_drops_valid: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && s1_clear_ff) |=> (entry_valid_ff == '0))
      else $error("clear left switch entries valid");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted word lost before decision stage");

   a_frame_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (^rsp_frame_ff == 1'b0))
      else $error("bus byte parity flag wrong");

   a_beep_to_panel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_action_ff == ACT_BEEP)) |-> (rsp_unit_ff == UNIT_PANEL))
      else $error("lock beep not sent to panel unit");

endmodule
